FILE: rtl/glig_pkg.sv
// Shared constants, state encoding and control structs of the grid LOD index generator.
package glig_pkg;

  // Fixed field widths
  localparam int CFG_W = 11;
  localparam int VIW   = 20;
  localparam int LVW   = 4;
  localparam int CRW   = 3;

  // Default largest grid side
  localparam int MAX_SIDE_DEF = 1024;

  // Position of the sixth index of a cell
  localparam logic [CRW-1:0] LAST_CORNER = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENTER,
    ST_DIV,
    ST_MUL,
    ST_BASE,
    ST_EMIT,
    ST_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_side;
    logic set_finished;
    logic div_start;
    logic div_take;
    logic mul;
    logic base;
    logic emit;
    logic step;
    logic emit_done;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic finished;
    logic div_big;
    logic div_done;
    logic out_free;
    logic last_corner;
    logic level_end;
  } ctrl_sts_t;

endpackage

FILE: rtl/glig_div.sv
// Restoring divider, one quotient bit per cycle, for the level stride.
module glig_div #(
  parameter int SW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [SW-1:0] num,
  input  logic [SW-1:0] den,
  output logic          done,
  output logic [SW-1:0] quo
);

  localparam int CNTW = $clog2(SW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [SW-1:0]   rem;
  logic [SW:0]     shifted;
  logic            ge;
  logic [SW:0]     diff;

  // one trial subtraction per cycle
  always_comb begin
    shifted = {rem, quo[SW-1]};
    ge      = shifted >= {1'b0, den};
    diff    = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // done pulses the cycle after the last quotient bit
      done <= busy && !start && (cnt == CNTW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(SW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      rem <= ge ? diff[SW-1:0] : shifted[SW-1:0];
      quo <= {quo[SW-2:0], ge};
    end
  end

endmodule

FILE: rtl/glig_dpath.sv
// Datapath: side and level registers, grid walk, index arithmetic and result register.
module glig_dpath #(
  parameter int MAX_SIDE = glig_pkg::MAX_SIDE_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [glig_pkg::CFG_W-1:0] cfg_side,
  input  glig_pkg::ctrl_cmd_t      cmd,
  output glig_pkg::ctrl_sts_t      sts,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [glig_pkg::LVW-1:0] level,
  output logic [glig_pkg::VIW-1:0] vertex_index,
  output logic [glig_pkg::CRW-1:0] corner,
  output logic                     last_of_cell,
  output logic                     last_of_level,
  output logic                     done_res
);

  import glig_pkg::*;

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = (SW > CFG_W) ? SW : CFG_W;

  logic [CFG_W-1:0] side_cfg;
  logic [SW-1:0]    side_l;
  logic [SW-1:0]    divisor;
  logic [SW-1:0]    stride;
  logic [SW-1:0]    row;
  logic [SW-1:0]    column;
  logic [LVW-1:0]   level_cnt;
  logic             finished;
  logic [VIW-1:0]   prod_row;
  logic [VIW-1:0]   prod_sm;
  logic [VIW-1:0]   base;
  logic [CRW-1:0]   corner_cnt;

  logic [SW-1:0]    side_sat;
  logic [SW:0]      col_sum;
  logic [SW:0]      row_sum;
  logic [SW:0]      lim;
  logic             wrap;
  logic             level_end;
  logic [2*SW-1:0]  mul_row;
  logic [2*SW-1:0]  mul_sm;
  logic [VIW-1:0]   idx;
  logic             out_free;
  logic             div_done;
  logic [SW-1:0]    div_quo;

  // side clamp at restart
  assign side_sat = (CW'(side_cfg) > CW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(side_cfg);

  // next cell position and end of level
  always_comb begin
    col_sum   = {1'b0, column} + {1'b0, stride};
    row_sum   = {1'b0, row} + {1'b0, stride};
    lim       = {1'b0, side_l - stride};
    wrap      = col_sum >= lim;
    level_end = wrap && (row_sum >= lim);
  end

  // products for the cell base and row offset
  assign mul_row = side_l * row;
  assign mul_sm  = side_l * stride;

  // index of the current corner
  always_comb begin
    unique case (corner_cnt)
      3'd0:    idx = base;
      3'd1:    idx = base + VIW'(stride);
      3'd2:    idx = base + prod_sm;
      3'd3:    idx = base + VIW'(stride);
      3'd4:    idx = base + prod_sm;
      3'd5:    idx = base + prod_sm + VIW'(stride);
      default: idx = base;
    endcase
  end

  assign out_free = !out_valid || !out_stall;

  glig_div #(.SW(SW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (side_l - 1'b1),
    .den   (divisor - 1'b1),
    .done  (div_done),
    .quo   (div_quo)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      side_cfg <= '0;
    end else if (cfg_we) begin
      side_cfg <= cfg_side;
    end
  end

  // level and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      side_l    <= '0;
      divisor   <= '0;
      stride    <= SW'(1);
      row       <= '0;
      column    <= '0;
      level_cnt <= '0;
      finished  <= 1'b1;
    end else begin
      if (cmd.load_side) begin
        side_l    <= side_sat;
        divisor   <= side_sat;
        level_cnt <= '0;
        stride    <= SW'(1);
      end
      if (cmd.set_finished) begin
        finished <= 1'b1;
      end
      if (cmd.div_take) begin
        stride   <= div_quo;
        row      <= '0;
        column   <= '0;
        finished <= 1'b0;
      end
      if (cmd.step) begin
        if (wrap) begin
          column <= '0;
          row    <= row_sum[SW-1:0];
        end else begin
          column <= col_sum[SW-1:0];
        end
        if (level_end) begin
          level_cnt <= level_cnt + 1'b1;
          divisor   <= {1'b0, divisor[SW-1:1]} + 1'b1;
        end
      end
    end
  end

  // cell arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_row <= VIW'(mul_row);
      prod_sm  <= VIW'(mul_sm);
    end
    if (cmd.base) begin
      base       <= prod_row + VIW'(column);
      corner_cnt <= '0;
    end else if (cmd.emit) begin
      corner_cnt <= corner_cnt + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_done) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      level         <= level_cnt;
      vertex_index  <= idx;
      corner        <= corner_cnt;
      last_of_cell  <= corner_cnt == LAST_CORNER;
      last_of_level <= (corner_cnt == LAST_CORNER) && level_end;
      done_res      <= 1'b0;
    end else if (cmd.emit_done) begin
      level         <= '0;
      vertex_index  <= '0;
      corner        <= '0;
      last_of_cell  <= 1'b0;
      last_of_level <= 1'b0;
      done_res      <= 1'b1;
    end
  end

  // status to controller
  always_comb begin
    sts.finished    = finished;
    sts.div_big     = divisor > SW'(2);
    sts.div_done    = div_done;
    sts.out_free    = out_free;
    sts.last_corner = corner_cnt == LAST_CORNER;
    sts.level_end   = level_end;
  end

endmodule

FILE: rtl/glig_ctrl.sv
// Controller state machine: item intake, level entry, cell emission sequence, done result.
module glig_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                restart,
  output logic                in_stall,
  input  glig_pkg::ctrl_sts_t sts,
  output glig_pkg::ctrl_cmd_t cmd
);

  import glig_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          priority if (restart) state_next = ST_ENTER;
          else if (sts.finished) state_next = ST_FIN;
          else state_next = ST_MUL;
        end
      end
      ST_ENTER: state_next = sts.div_big ? ST_DIV : ST_IDLE;
      ST_DIV: begin
        if (sts.div_done) state_next = ST_IDLE;
      end
      ST_MUL:  state_next = ST_BASE;
      ST_BASE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free && sts.last_corner) begin
          state_next = sts.level_end ? ST_ENTER : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_side = in_valid && restart;
      end
      ST_ENTER: begin
        cmd.div_start    = sts.div_big;
        cmd.set_finished = !sts.div_big;
      end
      ST_DIV:  cmd.div_take = sts.div_done;
      ST_MUL:  cmd.mul = 1'b1;
      ST_BASE: cmd.base = 1'b1;
      ST_EMIT: begin
        cmd.emit = sts.out_free;
        cmd.step = sts.out_free && sts.last_corner;
      end
      ST_FIN:  cmd.emit_done = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/grid_lod_index_generator.sv
// Top level: grid LOD triangle index generator, controller plus datapath.
// Advance item: the cell passes the MUL and BASE states before its first index reaches
//   the output register, then one index per cycle while the output is not stalled.
// Restart, and the end of each level: if the divisor exceeds 2, the stride divider
//   (SW bits, SW = clog2(MAX_SIDE+1), 11 by default) computes the new stride; otherwise the block reads as finished.
// Done item: one result. One item is in work at a time.
// Reset: synchronous; grid_side clears to 0, the block reads as finished until restart.
module grid_lod_index_generator #(
  parameter int MAX_SIDE = glig_pkg::MAX_SIDE_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [glig_pkg::CFG_W-1:0] grid_side,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     restart,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [glig_pkg::LVW-1:0] level,
  output logic [glig_pkg::VIW-1:0] vertex_index,
  output logic [glig_pkg::CRW-1:0] corner,
  output logic                     last_of_cell,
  output logic                     last_of_level,
  output logic                     done_res
);

  import glig_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  glig_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .restart  (restart),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  glig_dpath #(.MAX_SIDE(MAX_SIDE)) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_side      (grid_side),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .level         (level),
    .vertex_index  (vertex_index),
    .corner        (corner),
    .last_of_cell  (last_of_cell),
    .last_of_level (last_of_level),
    .done_res      (done_res)
  );

endmodule
